// File: design/assert_macros.svh
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on the rising clock edge, skipped while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on the rising clock edge in every cycle, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/cdir_pkg.sv
// types, codes and command tables for the disc-controller interrupt router
`timescale 1ns / 1ps

package cdir_pkg;

  localparam int RespLen     = 8;
  localparam int NumCommands = 32;
  localparam int CmdW        = $clog2(NumCommands);
  localparam int CountW      = 4;

  localparam logic [7:0] StatusLid     = 8'h10;
  localparam logic [7:0] StatusErrMask = 8'h1d;

  // per command bit, command 0 in bit 0
  localparam logic [NumCommands-1:0] AckHoldTab     = 32'h0464_0780;
  localparam logic [NumCommands-1:0] StatusValidTab = 32'hfffc_ffff;

  typedef enum logic [2:0] {
    FuncInterrupt = 3'd0,
    FuncCommand   = 3'd1,
    FuncSyncPoll  = 3'd2,
    FuncReadyPoll = 3'd3,
    FuncFlush     = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    IntNone      = 3'd0,
    IntDataReady = 3'd1,
    IntComplete  = 3'd2,
    IntAck       = 3'd3,
    IntDataEnd   = 3'd4,
    IntDiskError = 3'd5
  } int_code_e;

  localparam logic [2:0] SyncPending  = 3'd0;
  localparam logic [2:0] SyncComplete = 3'd2;
  localparam logic [2:0] SyncAck      = 3'd3;
  localparam logic [2:0] SyncErr      = 3'd5;

  localparam logic [2:0] ReadyNone = 3'd0;
  localparam logic [2:0] ReadyData = 3'd1;
  localparam logic [2:0] ReadyEnd  = 3'd4;
  localparam logic [2:0] ReadyErr  = 3'd5;

  localparam logic [2:0] EndNone = 3'd0;
  localparam logic [2:0] EndData = 3'd4;

  localparam logic [2:0] DispNone      = 3'd0;
  localparam logic [2:0] DispAckHold   = 3'd1;
  localparam logic [2:0] DispSync      = 3'd2;
  localparam logic [2:0] DispReady     = 3'd4;
  localparam logic [2:0] DispSyncReady = 3'd6;

  localparam logic [2:0] PollNone = 3'd0;

endpackage

// File: design/cdrom_interrupt_router_unit.sv
// disc-controller interrupt router: flag and result buffer update, one item per clock unless stalled
`timescale 1ns / 1ps

// Takes one item per clock unless stalled (interrupt, command issued, sync poll,
// ready poll or flush) and gives exactly one result item for each, in the cycle
// after acceptance. All flag, status and buffer updates are done in combinational
// logic between the input handshake and the result register, so the sustained
// rate is one item per cycle unless stalled. The result register parts the two
// sides: a new item is taken whenever the result register is empty or its item
// is being taken in the same cycle; in_stall_o rises only while a result waits
// under out_stall_i. No state needs clearing after reset beyond the reset itself.
`include "assert_macros.svh"

module cdrom_interrupt_router_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [2:0]  int_code_i,
  input  logic [3:0]  resp_count_i,
  input  logic [63:0] resp_bytes_i,
  input  logic [4:0]  command_i,
  input  logic        clears_ready_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  dispatch_code_o,
  output logic [2:0]  sync_code_o,
  output logic [2:0]  ready_code_o,
  output logic [2:0]  end_code_o,
  output logic [7:0]  status_byte_o,
  output logic [7:0]  status_ext_o,
  output logic [15:0] lid_open_count_o,
  output logic        disk_error_o,
  output logic        unknown_interrupt_o,
  output logic [2:0]  poll_value_o,
  output logic [63:0] result_bytes_o
);

  // architectural state
  logic [2:0]  sync_q, sync_d;
  logic [2:0]  ready_q, ready_d;
  logic [2:0]  end_q, end_d;
  logic [7:0]  status_q, status_d;
  logic [7:0]  status_ext_q, status_ext_d;
  logic [15:0] lid_q, lid_d;
  logic [cdir_pkg::CmdW-1:0] cmd_q, cmd_d;
  logic [63:0] sync_buf_q, sync_buf_d;
  logic [63:0] ready_buf_q, ready_buf_d;
  logic [63:0] end_buf_q, end_buf_d;

  // result register
  logic        out_valid_q;
  logic [2:0]  dispatch_q, dispatch_d;
  logic        disk_err_q, disk_err_d;
  logic        unknown_q, unknown_d;
  logic [2:0]  poll_q, poll_d;
  logic [63:0] result_q, result_d;

  logic        accept;
  logic [cdir_pkg::CountW-1:0] n_valid;
  logic [63:0] resp;
  logic [7:0]  b0;
  logic [7:0]  b1;
  logic        take_status;
  logic        err;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  // clamp the byte count and zero the bytes past it
  always_comb begin
    if (resp_count_i > cdir_pkg::CountW'(cdir_pkg::RespLen)) begin
      n_valid = cdir_pkg::CountW'(cdir_pkg::RespLen);
    end else begin
      n_valid = resp_count_i;
    end
    for (int i = 0; i < 8; i++) begin
      resp[i*8 +: 8] = (cdir_pkg::CountW'(i) < n_valid) ? resp_bytes_i[i*8 +: 8] : 8'h00;
    end
  end

  assign b0 = resp[7:0];
  assign b1 = resp[15:8];

  // status is ignored with no interrupt and on an ack for commands without a valid status
  assign take_status = (int_code_i != cdir_pkg::IntNone) &&
                       ((int_code_i != cdir_pkg::IntAck) || cdir_pkg::StatusValidTab[cmd_q]);
  assign err = take_status && ((b0 & cdir_pkg::StatusErrMask) != 8'h00);

  always_comb begin
    sync_d       = sync_q;
    ready_d      = ready_q;
    end_d        = end_q;
    status_d     = status_q;
    status_ext_d = status_ext_q;
    lid_d        = lid_q;
    cmd_d        = cmd_q;
    sync_buf_d   = sync_buf_q;
    ready_buf_d  = ready_buf_q;
    end_buf_d    = end_buf_q;
    dispatch_d   = cdir_pkg::DispNone;
    disk_err_d   = 1'b0;
    unknown_d    = 1'b0;
    poll_d       = cdir_pkg::PollNone;
    result_d     = 64'd0;

    unique case (func_i)
      cdir_pkg::FuncInterrupt: begin
        if (take_status) begin
          if (((status_q & cdir_pkg::StatusLid) == 8'h00) &&
              ((b0 & cdir_pkg::StatusLid) != 8'h00)) begin
            lid_d = lid_q + 16'd1;
          end
          status_d     = b0;
          status_ext_d = b1;
        end
        unique case (int_code_i)
          cdir_pkg::IntNone: begin
            dispatch_d = cdir_pkg::DispNone;
          end
          cdir_pkg::IntAck: begin
            sync_buf_d = resp;
            if (err) begin
              sync_d     = cdir_pkg::SyncErr;
              dispatch_d = cdir_pkg::DispSync;
            end else if (cdir_pkg::AckHoldTab[cmd_q]) begin
              sync_d     = cdir_pkg::SyncAck;
              dispatch_d = cdir_pkg::DispAckHold;
            end else begin
              sync_d     = cdir_pkg::SyncComplete;
              dispatch_d = cdir_pkg::DispSync;
            end
          end
          cdir_pkg::IntComplete: begin
            sync_d     = err ? cdir_pkg::SyncErr : cdir_pkg::SyncComplete;
            sync_buf_d = resp;
            dispatch_d = cdir_pkg::DispSync;
          end
          cdir_pkg::IntDataReady: begin
            // a single-byte data-ready response carries no error
            ready_d     = (err && (n_valid != cdir_pkg::CountW'(1))) ?
                          cdir_pkg::ReadyErr : cdir_pkg::ReadyData;
            ready_buf_d = resp;
            dispatch_d  = cdir_pkg::DispReady;
          end
          cdir_pkg::IntDataEnd: begin
            ready_d     = cdir_pkg::ReadyEnd;
            end_d       = cdir_pkg::EndData;
            end_buf_d   = resp;
            ready_buf_d = resp;
            dispatch_d  = cdir_pkg::DispReady;
          end
          cdir_pkg::IntDiskError: begin
            disk_err_d  = 1'b1;
            sync_d      = cdir_pkg::SyncErr;
            ready_d     = cdir_pkg::ReadyErr;
            sync_buf_d  = resp;
            ready_buf_d = resp;
            dispatch_d  = cdir_pkg::DispSyncReady;
          end
          default: begin
            unknown_d = 1'b1;
          end
        endcase
      end
      cdir_pkg::FuncCommand: begin
        sync_d = cdir_pkg::SyncPending;
        if (clears_ready_i) begin
          ready_d = cdir_pkg::ReadyNone;
        end
        cmd_d = command_i;
      end
      cdir_pkg::FuncSyncPoll: begin
        if ((sync_q == cdir_pkg::SyncComplete) || (sync_q == cdir_pkg::SyncErr)) begin
          poll_d   = sync_q;
          sync_d   = cdir_pkg::SyncComplete;
          result_d = sync_buf_q;
        end
      end
      cdir_pkg::FuncReadyPoll: begin
        // data end wins over a plain ready
        if (end_q != cdir_pkg::EndNone) begin
          poll_d   = end_q;
          end_d    = cdir_pkg::EndNone;
          result_d = end_buf_q;
        end else if (ready_q != cdir_pkg::ReadyNone) begin
          poll_d   = ready_q;
          ready_d  = cdir_pkg::ReadyNone;
          result_d = ready_buf_q;
        end
      end
      cdir_pkg::FuncFlush: begin
        end_d   = cdir_pkg::EndNone;
        ready_d = cdir_pkg::ReadyNone;
        sync_d  = cdir_pkg::SyncComplete;
      end
      default: begin
        poll_d = cdir_pkg::PollNone;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q       <= cdir_pkg::SyncComplete;
      ready_q      <= cdir_pkg::ReadyNone;
      end_q        <= cdir_pkg::EndNone;
      status_q     <= 8'h00;
      status_ext_q <= 8'h00;
      lid_q        <= 16'd0;
      cmd_q        <= '0;
      sync_buf_q   <= 64'd0;
      ready_buf_q  <= 64'd0;
      end_buf_q    <= 64'd0;
      out_valid_q  <= 1'b0;
    end else begin
      if (accept) begin
        sync_q       <= sync_d;
        ready_q      <= ready_d;
        end_q        <= end_d;
        status_q     <= status_d;
        status_ext_q <= status_ext_d;
        lid_q        <= lid_d;
        cmd_q        <= cmd_d;
        sync_buf_q   <= sync_buf_d;
        ready_buf_q  <= ready_buf_d;
        end_buf_q    <= end_buf_d;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded with each accepted item
  logic [2:0]  sync_out_q, ready_out_q, end_out_q;
  logic [7:0]  status_out_q, status_ext_out_q;
  logic [15:0] lid_out_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dispatch_q       <= dispatch_d;
      sync_out_q       <= sync_d;
      ready_out_q      <= ready_d;
      end_out_q        <= end_d;
      status_out_q     <= status_d;
      status_ext_out_q <= status_ext_d;
      lid_out_q        <= lid_d;
      disk_err_q       <= disk_err_d;
      unknown_q        <= unknown_d;
      poll_q           <= poll_d;
      result_q         <= result_d;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign dispatch_code_o     = dispatch_q;
  assign sync_code_o         = sync_out_q;
  assign ready_code_o        = ready_out_q;
  assign end_code_o          = end_out_q;
  assign status_byte_o       = status_out_q;
  assign status_ext_o        = status_ext_out_q;
  assign lid_open_count_o    = lid_out_q;
  assign disk_error_o        = disk_err_q;
  assign unknown_interrupt_o = unknown_q;
  assign poll_value_o        = poll_q;
  assign result_bytes_o      = result_q;

  `ASSERT_CLK(a_lid_only_on_item, clk_i, rst_ni, !accept |=> $stable(lid_q), "lid count moved without an item")
  `ASSERT_CLK(a_sync_err_poll, clk_i, rst_ni, (accept && (func_i == cdir_pkg::FuncSyncPoll) && (sync_q == cdir_pkg::SyncErr)) |=> (out_valid_o && (poll_value_o == cdir_pkg::SyncErr) && (sync_code_o == cdir_pkg::SyncComplete)), "sync error poll not reported")
  `ASSERT_CLK(a_disk_err_dispatch, clk_i, rst_ni, (out_valid_o && disk_error_o) |-> (dispatch_code_o == cdir_pkg::DispSyncReady), "disk error without sync and ready dispatch")

endmodule
